// File: rtl/core/mandelbrot_escape_count_unit_macros.svh
// Assertion macros shared by the escape-count unit.
`ifndef MANDELBROT_ESCAPE_COUNT_UNIT_MACROS_SVH
`define MANDELBROT_ESCAPE_COUNT_UNIT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MEC_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define MEC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/mec_pkg.sv
`timescale 1ns / 1ps

package mec_pkg;

    // Field widths of the stream words.
    localparam int IN_WIDTH    = 28;
    localparam int COUNT_WIDTH = 8;

    // Reset value of the iteration limit register.
    localparam logic [COUNT_WIDTH-1:0] LIMIT_RESET = 8'd255;

    // Escape test compares |z|^2 against this radius squared.
    localparam int ESCAPE_RADIUS_SQ = 4;

    // One queued point; c_real sits in the low bits.
    typedef struct packed {
        logic [IN_WIDTH-1:0] c_imag;
        logic [IN_WIDTH-1:0] c_real;
    } point_t;

    // Iteration engine states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_UPD,
        ST_HOLD
    } core_state_t;

endpackage

// File: rtl/core/mec_queue.sv
`timescale 1ns / 1ps

module mec_queue
    import mec_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  point_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output point_t out_data
);

    // Two-entry queue between the stream input and the iteration engine.
    point_t      slot0_reg;
    point_t      slot1_reg;
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  level_reg;
    logic [1:0]  level_next;
    logic        push;
    logic        pop;

    assign in_ready  = (level_reg != 2'd2);
    assign out_valid = (level_reg != 2'd0);
    assign out_data  = rd_ptr_reg ? slot1_reg : slot0_reg;

    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    // Pointer and fill level update.
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        level_next  = level_reg;
        if (push && !pop) begin
            level_next = level_reg + 2'd1;
        end else if (pop && !push) begin
            level_next = level_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Storage slots carry payload only.
    always_ff @(posedge aclk) begin
        if (push && !wr_ptr_reg) begin
            slot0_reg <= in_data;
        end
        if (push && wr_ptr_reg) begin
            slot1_reg <= in_data;
        end
    end

endmodule

// File: rtl/core/mec_core.sv
`timescale 1ns / 1ps

module mec_core
    import mec_pkg::*;
#(
    parameter int FRACTION_BITS = 26
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [COUNT_WIDTH-1:0] limit,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  point_t                 in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [COUNT_WIDTH-1:0] out_count,
    output logic                   busy
);

    // z stays below 4 + |c| in magnitude; ZW holds that with a sign bit to spare.
    localparam int ZMAG = (FRACTION_BITS + 3 > IN_WIDTH - 1) ? FRACTION_BITS + 3 : IN_WIDTH - 1;
    localparam int ZW   = ZMAG + 2;
    localparam int PW   = 2 * ZW;
    localparam int SW   = PW - FRACTION_BITS;
    localparam logic [SW:0] BOUND = (SW + 1)'(ESCAPE_RADIUS_SQ) << FRACTION_BITS;

    core_state_t            state_reg;
    core_state_t            state_next;
    logic signed [ZW-1:0]   zr_reg;
    logic signed [ZW-1:0]   zr_next;
    logic signed [ZW-1:0]   zi_reg;
    logic signed [ZW-1:0]   zi_next;
    logic [ZW-1:0]          cr_reg;
    logic [ZW-1:0]          cr_next;
    logic [ZW-1:0]          ci_reg;
    logic [ZW-1:0]          ci_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic signed [PW-1:0]   prr_reg;
    logic signed [PW-1:0]   pii_reg;
    logic signed [PW-1:0]   pri_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [COUNT_WIDTH-1:0] out_count_reg;
    logic [COUNT_WIDTH-1:0] out_count_next;
    logic [SW-1:0]          sr;
    logic [SW-1:0]          si;
    logic [SW:0]            mag_sq;
    logic                   iter_go;
    logic                   out_free;
    logic [ZW-1:0]          zr_new;
    logic [ZW-1:0]          zi_new;

    assign in_ready  = (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_count = out_count_reg;

    // Squares and cross product of z, one register stage.
    always_ff @(posedge aclk) begin
        prr_reg <= zr_reg * zr_reg;
        pii_reg <= zi_reg * zi_reg;
        pri_reg <= zr_reg * zi_reg;
    end

    // Floor-shifted squares; both are non-negative.
    assign sr     = prr_reg[PW-1:FRACTION_BITS];
    assign si     = pii_reg[PW-1:FRACTION_BITS];
    assign mag_sq = {1'b0, sr} + {1'b0, si};
    assign iter_go = (mag_sq < BOUND) && (count_reg < limit);

    // Next z, wrapped to ZW bits; the true value always fits when it is used.
    assign zr_new = sr[ZW-1:0] - si[ZW-1:0] + cr_reg;
    assign zi_new = pri_reg[ZW+FRACTION_BITS-2:FRACTION_BITS-1] + ci_reg;

    // The output word register is free when empty or being taken.
    assign out_free = !out_valid_reg || out_ready;

    // Engine control: load a point, alternate multiply and update, then deliver.
    always_comb begin
        state_next     = state_reg;
        zr_next        = zr_reg;
        zi_next        = zi_reg;
        cr_next        = cr_reg;
        ci_next        = ci_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_count_next = out_count_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cr_next    = {{(ZW-IN_WIDTH){in_data.c_real[IN_WIDTH-1]}}, in_data.c_real};
                    ci_next    = {{(ZW-IN_WIDTH){in_data.c_imag[IN_WIDTH-1]}}, in_data.c_imag};
                    zr_next    = '0;
                    zi_next    = '0;
                    count_next = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (iter_go) begin
                    zr_next    = $signed(zr_new);
                    zi_next    = $signed(zi_new);
                    count_next = count_reg + 1'b1;
                    state_next = ST_MUL;
                end else if (out_free) begin
                    out_valid_next = 1'b1;
                    out_count_next = count_reg;
                    state_next     = ST_IDLE;
                end else begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_count_next = count_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers carry payload only.
    always_ff @(posedge aclk) begin
        zr_reg        <= zr_next;
        zi_reg        <= zi_next;
        cr_reg        <= cr_next;
        ci_reg        <= ci_next;
        count_reg     <= count_next;
        out_count_reg <= out_count_next;
    end

endmodule

// File: rtl/core/mandelbrot_escape_count_unit.sv
// A point passes from the queue into the engine, which alternates its multiply state and
// update state once per iteration, then registers the count in its output word register.
// The engine takes one point at a time and takes the next only when it is idle again.
// A two-word queue takes new points while the engine iterates or a result waits.
// Reset (aresetn low, synchronous) empties the queue and output and sets the limit to 255.
`timescale 1ns / 1ps

`include "mandelbrot_escape_count_unit_macros.svh"

module mandelbrot_escape_count_unit
    import mec_pkg::*;
#(
    parameter int FRACTION_BITS = 26
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,  // iteration_limit
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,      // c_real [27:0], c_imag [55:28]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata       // iteration_count [7:0]
);

    logic [COUNT_WIDTH-1:0] limit_reg;
    logic [COUNT_WIDTH-1:0] limit_next;
    point_t                 q_data;
    logic                   q_valid;
    logic                   q_ready;
    logic                   core_busy;

    // Iteration limit register.
    assign limit_next = cfg_wr_en ? cfg_wr_data : limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else begin
            limit_reg <= limit_next;
        end
    end

    // Front: input queue.
    mec_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (point_t'(s_tdata)),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    // Back: iteration engine with output word register.
    mec_core #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .limit     (limit_reg),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_data   (q_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_count (m_tdata),
        .busy      (core_busy)
    );

    // A point handed to the engine starts its work on the next cycle.
    `MEC_ASSERT_NEXT(a_take_starts, aclk, aresetn, q_valid && q_ready, core_busy, "engine did not start")

    // An empty queue always has room for a new word.
    `MEC_ASSERT_SAME(a_empty_ready, aclk, aresetn, !q_valid, s_tready, "empty queue not ready")

    // A result word only appears after the engine has worked on a point.
    `MEC_ASSERT_SAME(a_result_from_work, aclk, aresetn, $rose(m_tvalid), $past(core_busy), "result without work")

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import mec_pkg::*;

    localparam int FRACTION_BITS = 26;
    localparam int CYCLE_LIMIT   = 5_000_000;
    localparam int HOLD_CYCLES   = 2500;

    // Escape test bound, 4.0 in the block's fixed-point format.
    localparam longint ESCAPE_BOUND = longint'(ESCAPE_RADIUS_SQ) <<< FRACTION_BITS;

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [7:0]             cfg_wr_data = '0;  // iteration_limit
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [55:0]            s_tdata     = '0;  // c_real [27:0], c_imag [55:28]
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [7:0]             m_tdata;           // iteration_count [7:0]

    point_t                 pending_points[$];
    logic [COUNT_WIDTH-1:0] expected_counts[$];
    logic [COUNT_WIDTH-1:0] limit_model  = LIMIT_RESET;
    int unsigned            idle_max     = 17;
    bit                     point_taken  = 1'b0;
    bit                     result_taken = 1'b0;
    int unsigned            results_seen = 0;
    int unsigned            fail_count   = 0;
    int unsigned            cycle_count  = 0;
    int unsigned            send_gap     = 0;
    int unsigned            rx_wait      = 0;
    int unsigned            rx_hold      = 0;

    mandelbrot_escape_count_unit #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    always #4 aclk = ~aclk;

    // Iterates z = z*z + c from zero and counts steps until escape or the limit.
    // Squares and the cross product are floored by arithmetic shifts, as in the block.
    function automatic logic [COUNT_WIDTH-1:0] escape_count(input point_t pt,
                                                            input logic [COUNT_WIDTH-1:0] lim);
        logic signed [IN_WIDTH-1:0] re_bits;
        logic signed [IN_WIDTH-1:0] im_bits;
        longint cr, ci, zr, zi, sr, si, cross_term;
        int unsigned steps;
        bit done;
        re_bits = pt.c_real;
        im_bits = pt.c_imag;
        cr = re_bits;
        ci = im_bits;
        zr = 0;
        zi = 0;
        steps = 0;
        done = 1'b0;
        while (!done) begin
            sr = (zr * zr) >>> FRACTION_BITS;
            si = (zi * zi) >>> FRACTION_BITS;
            if (sr + si >= ESCAPE_BOUND || steps >= lim) begin
                done = 1'b1;
            end else begin
                cross_term = (zr * zi) >>> (FRACTION_BITS - 1);
                zr = sr - si + cr;
                zi = cross_term + ci;
                steps++;
            end
        end
        return steps[COUNT_WIDTH-1:0];
    endfunction

    function automatic point_t make_point(input int re, input int im);
        point_t pt;
        pt.c_real = re[IN_WIDTH-1:0];
        pt.c_imag = im[IN_WIDTH-1:0];
        return pt;
    endfunction

    // Random point: part spread over the whole field range, part over the region
    // around the set, part jittered around spots on its boundary where counts run long.
    function automatic point_t random_point();
        point_t pt;
        int unsigned pick;
        int re;
        int im;
        int jit_re;
        int jit_im;
        pick = $urandom_range(0, 9);
        jit_re = int'($urandom_range(0, 262144)) - 131072;
        jit_im = int'($urandom_range(0, 262144)) - 131072;
        if (pick < 4) begin
            pt.c_real = IN_WIDTH'($urandom);
            pt.c_imag = IN_WIDTH'($urandom);
        end else if (pick < 8) begin
            re = int'($urandom_range(0, 167772160)) - 134217728;
            im = int'($urandom_range(0, 167772160)) - 83886080;
            pt = make_point(re, im);
        end else begin
            case ($urandom_range(0, 5))
                0: pt = make_point(-50331648 + jit_re, 6710886 + jit_im);
                1: pt = make_point(16777216 + jit_re, jit_im);
                2: pt = make_point(-83886080 + jit_re, jit_im);
                3: pt = make_point(-6710886 + jit_re, 43620762 + jit_im);
                4: pt = make_point(18790482 + jit_re, 35567616 + jit_im);
                default: pt = make_point(-118782525 + jit_re, jit_im);
            endcase
        end
        return pt;
    endfunction

    // Blocks until no word is pending or in flight and every result has arrived.
    task automatic wait_idle();
        while (pending_points.size() != 0 || s_tvalid || expected_counts.size() != 0)
            @(negedge aclk);
    endtask

    // Writes a new limit while the block is idle, then queues a batch of random points.
    task automatic run_phase(input logic [COUNT_WIDTH-1:0] lim, input int n_points,
                             input int unsigned gap_max);
        int k;
        wait_idle();
        repeat (8) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lim;
        limit_model = lim;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        idle_max = gap_max;
        for (k = 0; k < n_points; k++)
            pending_points.push_back(random_point());
    endtask

    // Sample both handshakes, predict accepted points and check results.
    always @(posedge aclk) begin
        logic [COUNT_WIDTH-1:0] want;
        point_taken  = aresetn && s_tvalid && s_tready;
        result_taken = aresetn && m_tvalid && m_tready;
        if (point_taken)
            expected_counts.push_back(escape_count(point_t'(s_tdata), limit_model));
        if (result_taken) begin
            if (expected_counts.size() == 0) begin
                $error("iteration_count: expected none, actual %0d", m_tdata);
                fail_count++;
            end else begin
                want = expected_counts.pop_front();
                if (m_tdata !== want) begin
                    $error("iteration_count: expected %0d, actual %0d", want, m_tdata);
                    fail_count++;
                end
            end
            results_seen++;
        end
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Input driver: presents one word at a time with a random gap after each.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || point_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_points.size() != 0) begin
                s_tdata  <= pending_points.pop_front();
                s_tvalid <= 1'b1;
                send_gap = $urandom_range(0, idle_max);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: random stall per word, and now and then a long hold-off
    // so the input queue fills and the block stops taking points.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (result_taken) begin
                rx_wait = $urandom_range(0, idle_max);
                if (results_seen % 600 == 300)
                    rx_hold = HOLD_CYCLES;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed points under the reset limit: field extremes, bit patterns,
        // the real-axis tips, the cusp, a period-two point and slow boundary points.
        pending_points.push_back(make_point(0, 0));
        pending_points.push_back(make_point(-134217728, -134217728));
        pending_points.push_back(make_point(134217727, 134217727));
        pending_points.push_back(make_point(-134217728, 134217727));
        pending_points.push_back(make_point(134217727, -134217728));
        pending_points.push_back(make_point(-134217728, 0));
        pending_points.push_back(make_point(134217727, 0));
        pending_points.push_back(make_point(0, 134217727));
        pending_points.push_back(make_point(0, -134217728));
        pending_points.push_back(make_point(-1, -1));
        pending_points.push_back(make_point(1, 1));
        pending_points.push_back(make_point(32'h05555555, 32'h0AAAAAAA));
        pending_points.push_back(make_point(32'h0AAAAAAA, 32'h05555555));
        pending_points.push_back(make_point(-67108864, 0));
        pending_points.push_back(make_point(16777216, 0));
        pending_points.push_back(make_point(17448304, 0));
        pending_points.push_back(make_point(0, 67108864));
        pending_points.push_back(make_point(-50331648, 6710886));
        pending_points.push_back(make_point(-118782525, 0));
        for (int k = 0; k < 200; k++)
            pending_points.push_back(random_point());

        run_phase(8'd1, 150, 17);
        run_phase(8'd0, 40, 17);
        run_phase(8'd255, 400, 17);
        run_phase(COUNT_WIDTH'($urandom_range(3, 253)), 300, 0);
        run_phase(8'd2, 150, 17);
        run_phase(8'd254, 300, 17);
        run_phase(COUNT_WIDTH'($urandom_range(3, 253)), 250, 17);
        run_phase(8'd128, 200, 0);

        // Let the last result settle and make sure nothing stray follows.
        wait_idle();
        repeat (600) @(negedge aclk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
